### hw/rtl/lcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_pkg - shared types and constants
// widths, register indexes and the result record of the colour run block
// ----------------------------------------------------------------------------
package lcr_pkg;

  // row width bound, column counter saturates here
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int COL_W  = $clog2(MAX_ROW_WIDTH + 1);  // column / exclusive end
  localparam int POS_W  = $clog2(MAX_ROW_WIDTH);      // first column
  localparam int GAP_W  = 9;
  localparam int GAPCFG_W = 8;
  localparam int PUR_W  = 7;
  localparam int PROD_W = COL_W + PUR_W;
  localparam int CH_W   = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_GAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PURITY      = 1'd1;
  localparam int CFG_DATA_W = 8;

  // register reset values
  localparam logic [GAPCFG_W-1:0] ALLOWED_GAP_RST = 8'd1;
  localparam logic [PUR_W-1:0]    PURITY_RST      = 7'd94;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] left;
    logic [COL_W-1:0] right;
    logic [COL_W-1:0] hits;
  } result_t;

endpackage

### hw/rtl/lcr_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_classify - bluish colour test
// exact integer chroma rules on one rgb pixel, constant multiplies only
// ----------------------------------------------------------------------------
module lcr_classify
  import lcr_pkg::*;
(
  input  logic [CH_W-1:0] red_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] blue_i,
  output logic            cool_o
);

  logic [CH_W-1:0] mx, mn, chroma, br;
  logic [15:0]     c100, mx32, br100, c42, b100c18, g100;
  logic            b_ge_r;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    chroma  = mx - mn;
    b_ge_r  = blue_i >= red_i;
    br      = blue_i - red_i;
    c100    = 16'(chroma) * 16'd100;
    mx32    = 16'(mx) * 16'd32;
    br100   = 16'(br) * 16'd100;
    c42     = 16'(chroma) * 16'd42;
    b100c18 = 16'(blue_i) * 16'd100 + 16'(chroma) * 16'd18;
    g100    = 16'(green_i) * 16'd100;
    cool_o  = (mx >= 8'd48) && (chroma >= 8'd30) && (c100 >= mx32) &&
              b_ge_r && (br >= 8'd22) && (br100 >= c42) && (b100c18 >= g100);
  end

endmodule

### hw/rtl/lcr_run_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_run_track - run and best-run state
// gap-tolerant run tracking, purity check on run close, row-end result
// ----------------------------------------------------------------------------
module lcr_run_track
  import lcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                cool_i,
  input  logic                last_i,
  input  logic [GAPCFG_W-1:0] allowed_gap_i,
  input  logic [PUR_W-1:0]    purity_i,
  output result_t             result_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic             in_run_q, in_run_d;
  logic [POS_W-1:0] begin_q, begin_d;
  logic [COL_W-1:0] hits_q, hits_d;
  logic [GAP_W-1:0] gap_q, gap_d;
  logic [POS_W-1:0] best_begin_q, best_begin_d;
  logic [COL_W-1:0] best_end_q, best_end_d;
  logic [COL_W-1:0] best_hits_q, best_hits_d;

  logic              active, miss_close, close;
  logic [COL_W-1:0]  right, len, best_len;
  logic [PROD_W-1:0] hits_x100, pur_x_len;
  logic              accept;

  always_comb begin
    col_d        = col_q;
    in_run_d     = in_run_q;
    begin_d      = begin_q;
    hits_d       = hits_q;
    gap_d        = gap_q;
    best_begin_d = best_begin_q;
    best_end_d   = best_end_q;
    best_hits_d  = best_hits_q;
    miss_close   = 1'b0;

    // saturated columns are neither match nor miss
    active = col_q < COL_W'(MAX_ROW_WIDTH);
    if (active) begin
      if (cool_i) begin
        if (!in_run_q) begin
          in_run_d = 1'b1;
          begin_d  = POS_W'(col_q);
        end
        hits_d = hits_q + 1'b1;
        gap_d  = '0;
      end else if (in_run_q) begin
        gap_d      = gap_q + 1'b1;
        miss_close = gap_d > GAP_W'(allowed_gap_i);
      end
      col_d = col_q + 1'b1;
    end

    // run closes on a gap too long or at row end; trailing misses dropped
    close     = miss_close || (last_i && in_run_d);
    right     = col_d - COL_W'(gap_d);
    len       = (right > COL_W'(begin_d)) ? right - COL_W'(begin_d) : '0;
    best_len  = best_end_q - COL_W'(best_begin_q);
    hits_x100 = PROD_W'(hits_d) * PROD_W'(100);
    pur_x_len = PROD_W'(purity_i) * PROD_W'(len);
    accept    = close && (len > best_len) && (hits_x100 >= pur_x_len);

    if (accept) begin
      best_begin_d = begin_d;
      best_end_d   = right;
      best_hits_d  = hits_d;
    end

    result_o.found = best_end_d > COL_W'(best_begin_d);
    result_o.left  = best_begin_d;
    result_o.right = best_end_d;
    result_o.hits  = best_hits_d;

    if (close) begin
      in_run_d = 1'b0;
      begin_d  = '0;
      hits_d   = '0;
      gap_d    = '0;
    end
    if (last_i) begin
      col_d        = '0;
      best_begin_d = '0;
      best_end_d   = '0;
      best_hits_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      in_run_q     <= 1'b0;
      begin_q      <= '0;
      hits_q       <= '0;
      gap_q        <= '0;
      best_begin_q <= '0;
      best_end_q   <= '0;
      best_hits_q  <= '0;
    end else if (step_i) begin
      col_q        <= col_d;
      in_run_q     <= in_run_d;
      begin_q      <= begin_d;
      hits_q       <= hits_d;
      gap_q        <= gap_d;
      best_begin_q <= best_begin_d;
      best_end_q   <= best_end_d;
      best_hits_q  <= best_hits_d;
    end
  end

endmodule

### hw/rtl/longest_colour_run_per_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_colour_run_per_row - longest bluish colour run in each row
// classifies pixels, tracks gap-tolerant runs and reports the best per row
// ----------------------------------------------------------------------------
// usage:
//   slave stream: one rgb pixel per word, left to right, tlast on the row's
//   final pixel. master stream: one word per row, sent after the last pixel.
//   each pixel is classified on the way into the input register; from there
//   it updates the run state and, for the last pixel, loads the result
//   register, which drives m_axis_tvalid_o. throughput is one pixel per
//   cycle; pixels keep flowing while a result waits, and a row-end pixel
//   is the only one that can hold the input register.
//   when the receiver stalls, only a row-end pixel waits in the input
//   register for the result slot, and then the slave side holds off.
//   reset clears the run state, empties both registers and restores
//   allowed_gap to 1 and purity_percent to 94. configuration is written
//   through cfg_we_i / cfg_idx_i / cfg_data_i while the stream is idle.
//   a run ends on one miss more than allowed_gap or at row end; it becomes
//   the best when strictly longer and pure enough. columns beyond the row
//   bound are ignored but tlast still closes the row.
// ----------------------------------------------------------------------------
module longest_colour_run_per_row
  import lcr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i,  // pixel_red, pixel_green, pixel_blue
  input  logic                  s_axis_tlast_i,  // row_last
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [39:0]           m_axis_tdata_o,  // run_left, run_right, run_match_count, pad
  output logic                  m_axis_tuser_o   // run_found
);

  // configuration registers
  logic [GAPCFG_W-1:0] allowed_gap_q;
  logic [PUR_W-1:0]    purity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_gap_q <= ALLOWED_GAP_RST;
      purity_q      <= PURITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALLOWED_GAP: allowed_gap_q <= cfg_data_i;
        CFG_PURITY:      purity_q      <= cfg_data_i[PUR_W-1:0];
        default: ;
      endcase
    end
  end

  // classification ahead of the input register
  logic cool;

  lcr_classify u_classify (
    .red_i   (s_axis_tdata_i[7:0]),
    .green_i (s_axis_tdata_i[15:8]),
    .blue_i  (s_axis_tdata_i[23:16]),
    .cool_o  (cool)
  );

  // input register: classified pixel
  logic    in_vld_q, cool_q, last_q;
  logic    out_vld_q;
  result_t out_q;
  result_t result;
  logic    step, in_take;

  // a row-end word needs the result slot free (or emptying this cycle)
  assign step            = in_vld_q && (!last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cool_q <= cool;
      last_q <= s_axis_tlast_i;
    end
  end

  lcr_run_track u_run_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .cool_i        (cool_q),
    .last_i        (last_q),
    .allowed_gap_i (allowed_gap_q),
    .purity_i      (purity_q),
    .result_o      (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.found;
  assign m_axis_tdata_o  = {2'b00, out_q.hits, out_q.right, out_q.left};

endmodule
